// ----- sv/tdlm_pkg.sv -----
// Package for the two-digit LED matrix renderer: request codes, glyph codes,
// the 3x7 font and the struct handed from the glyph stages to the serialiser.
// It depends on nothing else.
package tdlm_pkg;

    localparam int ROWS    = 8;
    localparam int ROW_W   = 8;
    localparam int GLYPH_W = 4;
    localparam int DOT_POS = 3;

    localparam logic [1:0] OP_INT    = 2'd0;
    localparam logic [1:0] OP_TENTHS = 2'd1;
    localparam logic [1:0] OP_MODE   = 2'd2;
    localparam logic [1:0] OP_BLANK  = 2'd3;

    localparam logic [3:0] GL_M     = 4'd10;
    localparam logic [3:0] GL_BLANK = 4'd11;

    localparam logic [9:0] SAT_NUM  = 10'd99;
    localparam logic [9:0] SAT_MODE = 10'd9;
    localparam logic [7:0] RECIP_10 = 8'd205;

    typedef logic [ROWS*ROW_W-1:0] t_rows;

    typedef struct packed {
        logic  valid;
        t_rows rows;
    } t_blk;

    // Eight rows of one glyph, first row in the top nibble.
    function automatic logic [ROWS*GLYPH_W-1:0] glyph_bits(input logic [3:0] code);
        logic [ROWS*GLYPH_W-1:0] bits;
        unique case (code)
            4'd0:    bits = 32'h2555_5520;
            4'd1:    bits = 32'h2622_2270;
            4'd2:    bits = 32'h7117_4470;
            4'd3:    bits = 32'h7113_1170;
            4'd4:    bits = 32'h5557_1110;
            4'd5:    bits = 32'h7447_1570;
            4'd6:    bits = 32'h7447_5570;
            4'd7:    bits = 32'h7511_1110;
            4'd8:    bits = 32'h7552_5570;
            4'd9:    bits = 32'h7557_1570;
            GL_M:    bits = 32'h5775_5550;
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

// ----- sv/tdlm_serializer.sv -----
// Row serialiser for the two-digit LED matrix renderer: holds one block of
// eight rows and sends it as eight row writes, address 14 first.
// Depends on tdlm_pkg.
module tdlm_serializer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  tdlm_pkg::t_blk i_blk,
    output logic         o_take,
    input  logic         i_stall,
    output logic         o_valid,
    output logic [3:0]   o_row_addr,
    output logic [7:0]   o_row_data,
    output logic         o_last
);

    logic                 r_valid;
    logic [2:0]           r_idx;
    tdlm_pkg::t_rows      r_rows;
    logic                 w_xfer;

    assign w_xfer     = r_valid && !i_stall;
    assign o_take     = !r_valid || (w_xfer && o_last);
    assign o_valid    = r_valid;
    assign o_row_addr = {~r_idx, 1'b0};
    assign o_row_data = r_rows[tdlm_pkg::ROWS*tdlm_pkg::ROW_W-1 -: tdlm_pkg::ROW_W];
    assign o_last     = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (o_take) begin
            r_valid <= i_blk.valid;
            r_idx   <= 3'd0;
        end else if (w_xfer) begin
            r_idx   <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rows <= i_blk.rows;
        end else if (w_xfer) begin
            r_rows <= r_rows << tdlm_pkg::ROW_W;
        end
    end

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && !o_last) |=> (r_valid && r_idx == 3'($past(r_idx) + 3'd1)))
        else $error("row index did not advance after a transfer");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && o_last) |=> (r_idx == 3'd0))
        else $error("row index did not restart after the last row");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_blk.valid) |=> (r_valid && r_idx == 3'd0))
        else $error("block taken but not loaded");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_idx) && $stable(r_rows)))
        else $error("stalled row changed");

endmodule

// ----- sv/two_digit_led_matrix_renderer.sv -----
// Two-digit LED matrix renderer: saturation, digit split and glyph stages,
// followed by the row serialiser. Depends on tdlm_pkg and tdlm_serializer.
//
// Usage: a request (i_op, i_value) is transferred when i_valid is high and
// o_stall is low. Each request produces eight row writes (o_row_addr,
// o_row_data, o_last) transferred when o_valid is high and i_stall is low;
// addresses run 14, 12, ..., 0 and o_last marks the eighth write.
// After a request is transferred it passes the saturation, digit split,
// glyph and serialiser registers in turn before its first row write is
// presented. The single output channel carries eight rows per request,
// and the serialiser takes a new block only with the last row of the one
// before; the three front stages take requests in consecutive cycles
// until they are full, so o_stall rises only when the serialiser is busy
// and all front stages hold a request.
// Reset clears all valid bits; no row write is pending afterwards.
// While the receiver stalls, the current row write is held unchanged and
// the pipeline behind it fills and then stalls the sender.
module two_digit_led_matrix_renderer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [9:0] i_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_row_addr,
    output logic [7:0] o_row_data,
    output logic       o_last
);

    logic            r_a_valid;
    logic [1:0]      r_a_op;
    logic [6:0]      r_a_val;
    logic [6:0]      n_a_val;

    logic            r_b_valid;
    logic [3:0]      r_b_left;
    logic [3:0]      r_b_right;
    logic            r_b_dot;
    logic [3:0]      n_b_left;
    logic [3:0]      n_b_right;
    logic            n_b_dot;

    logic            r_c_valid;
    tdlm_pkg::t_rows r_c_rows;
    tdlm_pkg::t_rows n_c_rows;

    logic [14:0]     w_prod;
    logic [3:0]      w_tens;
    logic [6:0]      w_tens10;
    logic [31:0]     w_lbits;
    logic [31:0]     w_rbits;

    logic            w_take;
    logic            w_rdy_a;
    logic            w_rdy_b;
    logic            w_rdy_c;
    tdlm_pkg::t_blk  w_blk;

    assign w_rdy_c = !r_c_valid || w_take;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_stall = !w_rdy_a;

    always_comb begin
        if (i_op == tdlm_pkg::OP_MODE) begin
            n_a_val = (i_value > tdlm_pkg::SAT_MODE) ? 7'(tdlm_pkg::SAT_MODE) : i_value[6:0];
        end else begin
            n_a_val = (i_value > tdlm_pkg::SAT_NUM) ? 7'(tdlm_pkg::SAT_NUM) : i_value[6:0];
        end
    end

    assign w_prod   = 15'(r_a_val) * 15'(tdlm_pkg::RECIP_10);
    assign w_tens   = w_prod[14:11];
    assign w_tens10 = 7'(w_tens) * 7'd10;

    always_comb begin
        n_b_left  = w_tens;
        n_b_right = 4'(r_a_val - w_tens10);
        n_b_dot   = 1'b0;
        case (r_a_op)
            tdlm_pkg::OP_TENTHS: begin
                n_b_dot = 1'b1;
            end
            tdlm_pkg::OP_MODE: begin
                n_b_left  = tdlm_pkg::GL_M;
                n_b_right = r_a_val[3:0];
            end
            tdlm_pkg::OP_BLANK: begin
                n_b_left  = tdlm_pkg::GL_BLANK;
                n_b_right = tdlm_pkg::GL_BLANK;
            end
            default: begin
            end
        endcase
    end

    assign w_lbits = tdlm_pkg::glyph_bits(r_b_left);
    assign w_rbits = tdlm_pkg::glyph_bits(r_b_right);

    always_comb begin
        for (int k = 0; k < tdlm_pkg::ROWS; k++) begin
            n_c_rows[(tdlm_pkg::ROWS-1-k)*tdlm_pkg::ROW_W +: tdlm_pkg::ROW_W] =
                {w_lbits[(tdlm_pkg::ROWS-1-k)*tdlm_pkg::GLYPH_W +: tdlm_pkg::GLYPH_W],
                 w_rbits[(tdlm_pkg::ROWS-1-k)*tdlm_pkg::GLYPH_W +: tdlm_pkg::GLYPH_W]};
        end
        n_c_rows[tdlm_pkg::DOT_POS] = n_c_rows[tdlm_pkg::DOT_POS] | r_b_dot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_op  <= i_op;
            r_a_val <= n_a_val;
        end
        if (w_rdy_b) begin
            r_b_left  <= n_b_left;
            r_b_right <= n_b_right;
            r_b_dot   <= n_b_dot;
        end
        if (w_rdy_c) begin
            r_c_rows <= n_c_rows;
        end
    end

    assign w_blk.valid = r_c_valid;
    assign w_blk.rows  = r_c_rows;

    tdlm_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_blk      (w_blk),
        .o_take     (w_take),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_row_addr (o_row_addr),
        .o_row_data (o_row_data),
        .o_last     (o_last)
    );

    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (w_tens <= 4'd9 && w_tens10 <= r_a_val))
        else $error("digit split out of range");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && w_rdy_c) |=> r_c_valid)
        else $error("glyph stage lost a request");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_b_valid && r_c_valid && o_valid))
        else $error("stall raised with room in the pipeline");

endmodule

// ----- dv/two_digit_led_matrix_renderer_tb.sv -----
// Testbench for the two-digit LED matrix renderer: a directed table of requests and then
// random requests, with every row write checked against table rows or a built-in glyph predictor.
// Depends on tdlm_pkg and the two_digit_led_matrix_renderer RTL.
`timescale 1ns / 100ps

module two_digit_led_matrix_renderer_tb;

    localparam int CYCLE_LIMIT = 250000;
    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 320;
    localparam logic [31:0] M_LETTER = 32'h5775_5550;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  value;
        logic        typed;
        logic [63:0] rows;
    } t_req_entry;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
        logic       last;
    } t_row_write;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_op = tdlm_pkg::OP_INT;
    logic [9:0] i_value = '0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_row_addr;
    logic [7:0] o_row_data;
    logic       o_last;

    t_row_write pending_row_writes [$];
    t_req_entry directed_reqs [0:N_DIRECTED-1];
    int         error_count = 0;
    int         cycle_count = 0;
    int         requests_sent = 0;
    int         rows_checked = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    two_digit_led_matrix_renderer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_row_addr (o_row_addr),
        .o_row_data (o_row_data),
        .o_last     (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL two_digit_led_matrix_renderer");
        $finish;
    end

    // Eight rows of a digit glyph, first row in the top nibble.
    function automatic logic [31:0] digit_glyph(input logic [3:0] digit);
        logic [31:0] g;
        case (digit)
            4'd0:    g = 32'h2555_5520;
            4'd1:    g = 32'h2622_2270;
            4'd2:    g = 32'h7117_4470;
            4'd3:    g = 32'h7113_1170;
            4'd4:    g = 32'h5557_1110;
            4'd5:    g = 32'h7447_1570;
            4'd6:    g = 32'h7447_5570;
            4'd7:    g = 32'h7511_1110;
            4'd8:    g = 32'h7552_5570;
            default: g = 32'h7557_1570;
        endcase
        return g;
    endfunction

    function automatic logic [63:0] render_rows(input logic [1:0] op, input logic [9:0] value);
        logic [9:0]  v;
        logic [31:0] left_g;
        logic [31:0] right_g;
        logic [63:0] rows;
        v = value;
        left_g = '0;
        right_g = '0;
        case (op)
            tdlm_pkg::OP_INT, tdlm_pkg::OP_TENTHS: begin
                if (v > 10'd99) v = 10'd99;
                left_g = digit_glyph(4'(v / 10));
                right_g = digit_glyph(4'(v % 10));
            end
            tdlm_pkg::OP_MODE: begin
                if (v > 10'd9) v = 10'd9;
                left_g = M_LETTER;
                right_g = digit_glyph(v[3:0]);
            end
            default: ;
        endcase
        for (int k = 0; k < tdlm_pkg::ROWS; k++) begin
            rows[63-8*k -: 8] = {left_g[31-4*k -: 4], right_g[31-4*k -: 4]};
        end
        if (op == tdlm_pkg::OP_TENTHS) rows[tdlm_pkg::DOT_POS] = 1'b1;
        return rows;
    endfunction

    task automatic flag_mismatch(input string what, input int exp_v, input int got_v);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
        error_count++;
    endtask

    task automatic send_request(input logic [1:0] op, input logic [9:0] value,
                                input logic typed, input logic [63:0] typed_rows);
        logic [63:0] rows;
        t_row_write  w;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rows = typed ? typed_rows : render_rows(op, value);
        for (int k = 0; k < tdlm_pkg::ROWS; k++) begin
            w.addr = 4'(14 - 2 * k);
            w.data = rows[63-8*k -: 8];
            w.last = (k == tdlm_pkg::ROWS - 1);
            pending_row_writes.push_back(w);
        end
        requests_sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_row_write w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_row_writes.size() == 0) begin
                flag_mismatch("unexpected row write, address", 0, o_row_addr);
            end else begin
                w = pending_row_writes.pop_front();
                if (o_row_addr !== w.addr) flag_mismatch("row address", w.addr, o_row_addr);
                if (o_row_data !== w.data) flag_mismatch("row data", w.data, o_row_data);
                if (o_last !== w.last) flag_mismatch("last flag", w.last, o_last);
                rows_checked++;
            end
        end
    end

    initial begin
        logic [1:0] op;
        logic [9:0] value;
        directed_reqs = '{
            '{tdlm_pkg::OP_INT,    10'd0,    1'b1, 64'h2255_5555_5555_2200},
            '{tdlm_pkg::OP_INT,    10'd1023, 1'b1, 64'h7755_5577_1155_7700},
            '{tdlm_pkg::OP_TENTHS, 10'd1023, 1'b1, 64'h7755_5577_1155_7708},
            '{tdlm_pkg::OP_MODE,   10'd1023, 1'b1, 64'h5775_7557_5155_5700},
            '{tdlm_pkg::OP_MODE,   10'd0,    1'b1, 64'h5275_7555_5555_5200},
            '{tdlm_pkg::OP_BLANK,  10'd0,    1'b1, 64'h0},
            '{tdlm_pkg::OP_BLANK,  10'd1023, 1'b1, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd99,   1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd100,  1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd9,    1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd10,   1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd12,   1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd34,   1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd56,   1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd78,   1'b0, 64'h0},
            '{tdlm_pkg::OP_TENTHS, 10'd0,    1'b0, 64'h0},
            '{tdlm_pkg::OP_TENTHS, 10'd5,    1'b0, 64'h0},
            '{tdlm_pkg::OP_TENTHS, 10'd99,   1'b0, 64'h0},
            '{tdlm_pkg::OP_TENTHS, 10'd100,  1'b0, 64'h0},
            '{tdlm_pkg::OP_MODE,   10'd9,    1'b0, 64'h0},
            '{tdlm_pkg::OP_MODE,   10'd10,   1'b0, 64'h0},
            '{tdlm_pkg::OP_INT,    10'd512,  1'b0, 64'h0},
            '{tdlm_pkg::OP_TENTHS, 10'd341,  1'b0, 64'h0},
            '{tdlm_pkg::OP_MODE,   10'd682,  1'b0, 64'h0}
        };
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_reqs[i].op, directed_reqs[i].value,
                         directed_reqs[i].typed, directed_reqs[i].rows);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                op = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0: value = 10'($urandom_range(0, 12));
                    1: value = 10'($urandom_range(0, 110));
                    2: value = 10'($urandom_range(90, 105));
                    default: value = 10'($urandom_range(0, 1023));
                endcase
                send_request(op, value, 1'b0, 64'h0);
            end
        end
        i_valid <= 1'b0;

        while (pending_row_writes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests (%0d from the directed table) and %0d row writes,",
                 requests_sent, N_DIRECTED, rows_checked);
        $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
        if (error_count == 0) begin
            $display("PASS two_digit_led_matrix_renderer");
        end else begin
            $display("FAIL two_digit_led_matrix_renderer");
        end
        $finish;
    end

endmodule
